// File: rtl/kvi_pkg.sv
// ----------------------------------------------------------------------------
// kvi_pkg
// Shared types and constants of the keyframe vector interpolator.
// ----------------------------------------------------------------------------
package kvi_pkg;

  // Default depth of the key table.
  localparam int unsigned MAX_KEYS_DEF = 64;

  // Widths of the stream payloads.
  localparam int unsigned IN_TDATA_W  = 168;
  localparam int unsigned OUT_TDATA_W = 96;
  localparam int unsigned KEY_CNT_W   = 7;
  localparam int unsigned FACTOR_W    = 16;

  // Values of the action flag carried in the input tuser.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // One stored key: time in the low word, then x, y and z.
  typedef struct packed {
    logic [31:0] vz;
    logic [31:0] vy;
    logic [31:0] vx;
    logic [31:0] tk;
  } key_t;

  localparam int unsigned KEY_W = $bits(key_t);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_MUL,
    ST_ACC
  } state_e;

endpackage

// File: rtl/kvi_ram.sv
// ----------------------------------------------------------------------------
// kvi_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kvi_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/keyframe_vector_interpolator.sv
// A write beat gives its result in the cycle after it is accepted.
// A query reads one table entry per active key in a linear search, then runs
// the serial divider, and one multiplier serves the three components in turn.
// One beat is in flight at a time; the next beat is taken as its result leaves.
// Reset clears the sequencer and the output valid and sets the key count to one.
// ----------------------------------------------------------------------------
// keyframe_vector_interpolator
// Stores animation keys and returns the linearly interpolated key vector for
// a query time, clamping to the end keys outside the key span.
// ----------------------------------------------------------------------------
module keyframe_vector_interpolator #(
  parameter int unsigned MaxKeys = kvi_pkg::MAX_KEYS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration: key_count.
  input  logic                               cfg_we_i,
  input  logic [kvi_pkg::KEY_CNT_W-1:0]      cfg_wdata_i,
  // Input stream.
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: key_index[5:0], key_time[37:6], key_x[69:38], key_y[101:70],
  //        key_z[133:102], query_time[165:134], zero padding[167:166]
  input  logic [kvi_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // tuser: action[0]
  input  logic                               s_axis_tuser_i,
  // Output stream.
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tdata: out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [kvi_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // tuser: out_of_range[0]
  output logic                               m_axis_tuser_o
);

  import kvi_pkg::*;

  localparam int unsigned AW = $clog2(MaxKeys);
  localparam int unsigned NW = $clog2(MaxKeys + 1);

  // Input fields.
  logic [5:0]  key_index;
  logic [31:0] key_time, key_x, key_y, key_z, query_time;

  assign key_index  = s_axis_tdata_i[5:0];
  assign key_time   = s_axis_tdata_i[37:6];
  assign key_x      = s_axis_tdata_i[69:38];
  assign key_y      = s_axis_tdata_i[101:70];
  assign key_z      = s_axis_tdata_i[133:102];
  assign query_time = s_axis_tdata_i[165:134];

  // Registers.
  state_e                state_q, state_d;
  logic [KEY_CNT_W-1:0]  key_count_q;
  logic [NW-1:0]         n_q;
  logic [AW-1:0]         idx_q;
  logic [31:0]           t_q;
  key_t                  prev_q, cur_q;
  logic [31:0]           rem_q, den_q;
  logic [FACTOR_W-1:0]   quo_q;
  logic [3:0]            div_cnt_q;
  logic [1:0]            comp_q;
  logic signed [49:0]    prod_q;
  logic [31:0]           out_x_q, out_y_q, out_z_q;
  logic                  oor_q;
  logic                  m_valid_q;

  // Control from the sequencer.
  logic          s_accept;
  logic          wr_en;
  logic [AW-1:0] raddr;
  logic          emit_en;
  key_t          emit_key;
  logic          emit_oor;
  logic          advance;
  logic          start_div;

  // Key table.
  key_t wr_key;
  key_t rd;

  assign wr_key = '{vz: key_z, vy: key_y, vx: key_x, tk: key_time};

  kvi_ram #(
    .Width (KEY_W),
    .Depth (MaxKeys)
  ) u_kvi_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AW'(key_index)),
    .wdata_i (wr_key),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  // Active key count, clamped to the range one to MaxKeys.
  logic [NW-1:0] n_eff;
  always_comb begin
    int kc;
    kc = int'(key_count_q);
    if (kc == 0) begin
      n_eff = NW'(1);
    end else if (kc > int'(MaxKeys)) begin
      n_eff = NW'(MaxKeys);
    end else begin
      n_eff = NW'(kc);
    end
  end

  // Search conditions on the entry just read.
  logic single, before_cur, before_prev, at_first, at_last;
  assign single      = (n_q == NW'(1));
  assign before_cur  = (t_q < rd.tk);
  assign before_prev = (t_q < prev_q.tk);
  assign at_first    = (idx_q == '0);
  assign at_last     = (NW'(idx_q) == n_q - NW'(1));

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_accept && (s_axis_tuser_i == ACT_QUERY)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (single) begin
          state_d = ST_IDLE;
        end else if (at_first) begin
          state_d = before_cur ? ST_IDLE : ST_SCAN;
        end else if (before_cur) begin
          state_d = before_prev ? ST_IDLE : ST_DIV;
        end else begin
          state_d = at_last ? ST_IDLE : ST_SCAN;
        end
      end
      ST_DIV: begin
        if (div_cnt_q == 4'hF) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        state_d = (comp_q == 2'd2) ? ST_IDLE : ST_MUL;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready_o = 1'b0;
    wr_en           = 1'b0;
    raddr           = idx_q;
    emit_en         = 1'b0;
    emit_key        = rd;
    emit_oor        = 1'b0;
    advance         = 1'b0;
    start_div       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = !m_valid_q || m_axis_tready_i;
        raddr           = '0;
        wr_en           = s_accept && (s_axis_tuser_i == ACT_WRITE) &&
                          (int'(key_index) < int'(MaxKeys));
      end
      ST_SCAN: begin
        raddr = idx_q + AW'(1);
        if (single) begin
          emit_en = 1'b1;
        end else if (at_first) begin
          if (before_cur) begin
            emit_en  = 1'b1;
            emit_oor = 1'b1;
          end else begin
            advance = 1'b1;
          end
        end else if (before_cur) begin
          if (before_prev) begin
            emit_en  = 1'b1;
            emit_key = prev_q;
          end else begin
            start_div = 1'b1;
          end
        end else if (at_last) begin
          emit_en  = 1'b1;
          emit_oor = 1'b1;
        end else begin
          advance = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Restoring divider step: one quotient bit a cycle.
  logic [32:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, den_q});

  // Shared multiplier on the selected component.
  logic [31:0]        comp_a, comp_b;
  logic signed [32:0] diff;
  logic signed [16:0] factor_s;
  logic signed [49:0] prod_d;
  logic signed [33:0] sum;

  always_comb begin
    case (comp_q)
      2'd0:    begin comp_a = prev_q.vx; comp_b = cur_q.vx; end
      2'd1:    begin comp_a = prev_q.vy; comp_b = cur_q.vy; end
      default: begin comp_a = prev_q.vz; comp_b = cur_q.vz; end
    endcase
  end

  assign diff     = $signed({comp_b[31], comp_b}) - $signed({comp_a[31], comp_a});
  assign factor_s = $signed({1'b0, quo_q});
  assign prod_d   = factor_s * diff;
  // An arithmetic shift of the product floors toward minus infinity.
  assign sum      = $signed({{2{comp_a[31]}}, comp_a}) + prod_q[49:16];

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_count_q <= KEY_CNT_W'(1);
      m_valid_q   <= 1'b0;
      div_cnt_q   <= '0;
      comp_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        key_count_q <= cfg_wdata_i;
      end
      // Output valid: a new result wins over the pop of the old one.
      if ((s_accept && (s_axis_tuser_i == ACT_WRITE)) || emit_en ||
          ((state_q == ST_ACC) && (comp_q == 2'd2))) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (start_div) begin
        div_cnt_q <= '0;
      end else if (state_q == ST_DIV) begin
        div_cnt_q <= div_cnt_q + 4'd1;
      end
      if (start_div) begin
        comp_q <= '0;
      end else if (state_q == ST_ACC) begin
        comp_q <= comp_q + 2'd1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      t_q   <= query_time;
      n_q   <= n_eff;
      idx_q <= '0;
    end
    if (s_accept && (s_axis_tuser_i == ACT_WRITE)) begin
      out_x_q <= '0;
      out_y_q <= '0;
      out_z_q <= '0;
      oor_q   <= 1'b0;
    end
    if (advance) begin
      prev_q <= rd;
      idx_q  <= idx_q + AW'(1);
    end
    if (emit_en) begin
      out_x_q <= emit_key.vx;
      out_y_q <= emit_key.vy;
      out_z_q <= emit_key.vz;
      oor_q   <= emit_oor;
    end
    if (start_div) begin
      cur_q <= rd;
      rem_q <= t_q - prev_q.tk;
      den_q <= rd.tk - prev_q.tk;
      oor_q <= 1'b0;
    end
    if (state_q == ST_DIV) begin
      rem_q <= rem_ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
      quo_q <= {quo_q[FACTOR_W-2:0], rem_ge};
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod_d;
    end
    if (state_q == ST_ACC) begin
      case (comp_q)
        2'd0:    out_x_q <= sum[31:0];
        2'd1:    out_y_q <= sum[31:0];
        default: out_z_q <= sum[31:0];
      endcase
    end
  end

  // Output stream.
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {out_z_q, out_y_q, out_x_q};
  assign m_axis_tuser_o  = oor_q;

endmodule

// File: rtl/kvi_checker.sv
// ----------------------------------------------------------------------------
// kvi_checker
// Port-level checks of the keyframe vector interpolator, bound to its top.
// ----------------------------------------------------------------------------
module kvi_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            s_axis_tuser_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [kvi_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                            m_axis_tuser_o
);

  import kvi_pkg::*;

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result beat changed");

  // Input is taken only when the output register is free or being drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o || m_axis_tready_i)
    else $error("input ready while output register is blocked");

  // A write beat answers in the next cycle with an all-zero result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == ACT_WRITE) |=>
      m_axis_tvalid_o && (m_axis_tdata_o == '0) && !m_axis_tuser_o)
    else $error("write beat did not give a zero result");

  // A query occupies the block, so input is not ready in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == ACT_QUERY) |=>
      !s_axis_tready_o)
    else $error("input ready right after a query beat");

endmodule

bind keyframe_vector_interpolator kvi_checker u_kvi_checker (.*);
